[rtl/nearest_palette_color_unit_macros.svh]
// ----------------------------------------------------------------------------
// Nearest palette colour unit: assertion macros
// Shared assertion shorthands, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_UNIT_MACROS_SVH
`define NEAREST_PALETTE_COLOR_UNIT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define NPC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define NPC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define NPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/npc_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest palette colour package
// Payload types and fixed field widths of the nearest palette colour unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package npc_pkg;

	localparam int unsigned INDEX_W = 4;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned DIST_W  = 10;
	localparam int unsigned SIZE_W  = 5;
	localparam int unsigned COLOR_W = 3 * CHAN_W;

	localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = 5'd16;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] entry_index;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic               exclude_enable;
		logic [INDEX_W-1:0] exclude_index;
	} npc_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] best_index;
		logic [DIST_W-1:0]  best_distance;
		logic               found;
	} npc_rsp_t;

endpackage

[rtl/nearest_palette_color_unit.sv]
// ----------------------------------------------------------------------------
// Nearest palette colour unit: L1 nearest-entry search over an RGB palette.
// A write transfer is taken whenever the unit is idle. A query reads palette_size entries
// (clamped to the depth), one per cycle, through the RAM and distance stages, then waits for
// room in the result register; the next request can be taken once the result shows.
// Asynchronous active-low reset: idle, empty output, palette_size 16; palette contents unset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nearest_palette_color_unit_macros.svh"

module nearest_palette_color_unit
	import npc_pkg::*;
#(
	parameter int unsigned PALETTE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// Configuration: palette_size.
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_wdata,
	// Request channel.
	input  logic              req_valid,
	output logic              req_stall,
	input  npc_req_t          req,
	// Result channel.
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output npc_rsp_t          rsp
);

	localparam int unsigned AW = $clog2(PALETTE_DEPTH);

	// The palette lives in a single RAM. Writes are only taken while the
	// unit is idle and the scan reads only while it is busy, so a read and a
	// write never meet on the same entry and no forwarding is needed.

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   palette_size_q;

	// Query context captured when the query transfer is taken.
	logic [CHAN_W-1:0]   red_q;
	logic [CHAN_W-1:0]   green_q;
	logic [CHAN_W-1:0]   blue_q;
	logic                excl_en_q;
	logic [INDEX_W-1:0]  excl_ix_q;
	logic [SIZE_W-1:0]   size_eff_q;
	logic [SIZE_W-1:0]   scan_cnt_q;

	// Stage 1: RAM data returns. Stage 2: distance is known.
	logic                rd_v_s1;
	logic [INDEX_W-1:0]  idx_s1;
	logic                dv_s2;
	logic [INDEX_W-1:0]  idx_s2;
	logic [DIST_W-1:0]   dist_s2;

	// Running best.
	logic                have_q;
	logic [INDEX_W-1:0]  best_ix_q;
	logic [DIST_W-1:0]   best_d_q;

	// Output register.
	logic                rsp_valid_q;
	npc_rsp_t            rsp_q;

	logic                req_take;
	logic                wr_en;
	logic                rd_issue;
	logic                rd_excluded;
	logic [SIZE_W-1:0]   size_eff;
	logic [COLOR_W-1:0]  ram_rdata;
	logic [DIST_W-1:0]   dist_s1;
	logic                better;
	logic                rsp_free;
	logic                flush_done;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;

	// A write outside the store is dropped.
	assign wr_en = req_take && (req.kind == KIND_WRITE)
		&& (32'(req.entry_index) < PALETTE_DEPTH);

	// A size larger than the store is clamped to the store depth.
	assign size_eff = (32'(palette_size_q) > PALETTE_DEPTH) ?
		SIZE_W'(PALETTE_DEPTH) : palette_size_q;

	assign rd_issue    = (state_q == ST_SCAN) && (scan_cnt_q < size_eff_q);
	assign rd_excluded = excl_en_q && (scan_cnt_q == SIZE_W'(excl_ix_q));

	npc_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(req.entry_index)),
		.wdata ({req.red, req.green, req.blue}),
		.re    (rd_issue),
		.raddr (AW'(scan_cnt_q)),
		.rdata (ram_rdata)
	);

	// L1 distance of the entry that has just come out of the RAM.
	assign dist_s1 = DIST_W'(abs_diff(ram_rdata[3*CHAN_W-1:2*CHAN_W], red_q))
		+ DIST_W'(abs_diff(ram_rdata[2*CHAN_W-1:CHAN_W], green_q))
		+ DIST_W'(abs_diff(ram_rdata[CHAN_W-1:0], blue_q));

	// Strictly smaller wins, so on a tie the earlier (lower) index stays.
	assign better = dv_s2 && (!have_q || (dist_s2 < best_d_q));

	assign rsp_free   = !rsp_valid_q || !rsp_stall;
	assign flush_done = (state_q == ST_FLUSH) && !rd_v_s1 && !dv_s2 && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			palette_size_q <= PALETTE_SIZE_RESET;
			red_q          <= '0;
			green_q        <= '0;
			blue_q         <= '0;
			excl_en_q      <= 1'b0;
			excl_ix_q      <= '0;
			size_eff_q     <= '0;
			scan_cnt_q     <= '0;
			rd_v_s1        <= 1'b0;
			idx_s1         <= '0;
			dv_s2          <= 1'b0;
			idx_s2         <= '0;
			dist_s2        <= '0;
			have_q         <= 1'b0;
			best_ix_q      <= '0;
			best_d_q       <= '0;
			rsp_valid_q    <= 1'b0;
			rsp_q          <= '0;
		end else begin
			if (cfg_we) begin
				palette_size_q <= cfg_wdata;
			end

			// Pipeline advance.
			rd_v_s1 <= rd_issue && !rd_excluded;
			idx_s1  <= INDEX_W'(scan_cnt_q);
			dv_s2   <= rd_v_s1;
			idx_s2  <= idx_s1;
			dist_s2 <= dist_s1;

			if (better) begin
				have_q    <= 1'b1;
				best_ix_q <= idx_s2;
				best_d_q  <= dist_s2;
			end

			// The result register empties when its transfer completes.
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_take && (req.kind == KIND_QUERY)) begin
						red_q      <= req.red;
						green_q    <= req.green;
						blue_q     <= req.blue;
						excl_en_q  <= req.exclude_enable;
						excl_ix_q  <= req.exclude_index;
						size_eff_q <= size_eff;
						scan_cnt_q <= '0;
						have_q     <= 1'b0;
						best_ix_q  <= '0;
						best_d_q   <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// Wait for the last entry to leave the pipeline and for
					// room in the result register.
					if (flush_done) begin
						rsp_valid_q         <= 1'b1;
						rsp_q.best_index    <= best_ix_q;
						rsp_q.best_distance <= best_d_q;
						rsp_q.found         <= have_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A query transfer always starts a scan.
	`NPC_ASSERT_NEXT(a_query_starts_scan, req_take && (req.kind == KIND_QUERY), state_q == ST_SCAN, "query did not start a scan")
	// With nothing allowed, the result carries index and distance zero.
	`NPC_ASSERT_IMPLY(a_not_found_zero, rsp_valid && !rsp.found, (rsp.best_index == '0) && (rsp.best_distance == '0), "empty result not zero")
	// The pipeline holds nothing while the unit is idle.
	`NPC_ASSERT_IMPLY(a_idle_empty, state_q == ST_IDLE, !rd_v_s1 && !dv_s2, "pipeline busy while idle")
	// The scan never walks past the clamped size.
	`NPC_ASSERT_ALWAYS(a_scan_bound, (state_q != ST_SCAN) || (scan_cnt_q <= size_eff_q), "scan ran past palette size")

endmodule

[rtl/npc_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module npc_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[bench/nearest_palette_color_unit_tb.sv]
// ----------------------------------------------------------------------------
// Nearest palette colour unit: self-checking testbench
// Loads the palette through write transfers and sends query transfers. A
// scoreboard class keeps its own copy of the palette and of palette_size,
// works out the nearest entry for every accepted query, and compares each
// result transfer with the oldest expected match, field by field. Both
// channels idle at random; palette_size changes only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_palette_color_unit_tb;
	import npc_pkg::*;

	localparam int unsigned PALETTE_DEPTH = 16;
	// Long enough for a query to finish even at the largest size.
	localparam int unsigned QUERY_SETTLE  = PALETTE_DEPTH + 8;
	// Watchdog limit on the length of the whole run.
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned PHASES        = 9;
	localparam int unsigned PHASE_ITEMS   = 95;

	// palette_size for each random phase. Zero and the values above the depth
	// are legal register contents, so they are exercised as well. The random
	// size chosen for phase 7 overrides its entry here.
	localparam logic [SIZE_W-1:0] PHASE_SIZES [PHASES] = '{
		5'd16, 5'd3, 5'd31, 5'd1, 5'd9, 5'd17, 5'd0, 5'd14, 5'd16
	};

	// Holds the palette as the block should see it and the queue of nearest
	// matches still owed by the block.
	class nearest_color_predictor #(int unsigned DEPTH = 16);
		logic [COLOR_W-1:0] palette [DEPTH];
		logic [SIZE_W-1:0]  size = PALETTE_SIZE_RESET;
		npc_rsp_t           expected_matches [$];
		int unsigned        errors = 0;

		function int unsigned channel_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		// Called for every accepted request transfer.
		function void note_request(npc_req_t item);
			int unsigned span;
			int unsigned gap;
			npc_rsp_t    match;
			if (item.kind == KIND_WRITE) begin
				if (item.entry_index < DEPTH)
					palette[item.entry_index] = {item.red, item.green, item.blue};
				return;
			end
			// Sizes above the depth search the whole palette.
			span = (size > DEPTH) ? DEPTH : size;
			match = '0;
			for (int unsigned i = 0; i < span; i++) begin
				if (item.exclude_enable && i == item.exclude_index)
					continue;
				gap = channel_gap(palette[i][2*CHAN_W +: CHAN_W], item.red)
					+ channel_gap(palette[i][CHAN_W +: CHAN_W], item.green)
					+ channel_gap(palette[i][0 +: CHAN_W], item.blue);
				// Strictly smaller only, so the lowest index wins a tie.
				if (!match.found || gap < match.best_distance) begin
					match.found         = 1'b1;
					match.best_distance = gap[DIST_W-1:0];
					match.best_index    = i[INDEX_W-1:0];
				end
			end
			expected_matches.push_back(match);
		endfunction

		// Called for every accepted result transfer.
		function void check_match(npc_rsp_t got);
			npc_rsp_t want;
			if (expected_matches.size() == 0) begin
				$error("unexpected result: best_index %0d, best_distance %0d, found %0d",
					got.best_index, got.best_distance, got.found);
				errors++;
				return;
			end
			want = expected_matches.pop_front();
			if (got.best_index !== want.best_index) begin
				$error("best_index: expected %0d, actual %0d", want.best_index, got.best_index);
				errors++;
			end
			if (got.best_distance !== want.best_distance) begin
				$error("best_distance: expected %0d, actual %0d",
					want.best_distance, got.best_distance);
				errors++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, got.found);
				errors++;
			end
		endfunction
	endclass

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [SIZE_W-1:0] cfg_wdata = '0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	npc_req_t          req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	npc_rsp_t          rsp;

	// Random idling on both channels is switched off for some phases.
	bit                idling_on   = 1'b1;
	int unsigned       stall_left  = 0;
	int unsigned       cycle_count = 0;

	nearest_color_predictor #(PALETTE_DEPTH) matcher = new;

	nearest_palette_color_unit #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nearest_palette_color_unit_tb: done, errors");
			$finish;
		end
	end

	// The result side stalls in bursts of random length. Once a burst has
	// started it runs to its end even if idling has just been switched off.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 5);
			rsp_stall  <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Values are read at the clock edge before any update of that edge lands,
	// so the transfer seen here is the one the block also saw.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			matcher.check_match(rsp);
	end

	// The fields a write ignores are still filled with random values, so the
	// block is shown that they make no difference.
	function automatic npc_req_t palette_write(logic [INDEX_W-1:0] ix,
		logic [COLOR_W-1:0] rgb);
		npc_req_t item;
		item.kind           = KIND_WRITE;
		item.entry_index    = ix;
		{item.red, item.green, item.blue} = rgb;
		item.exclude_enable = 1'($urandom_range(0, 1));
		item.exclude_index  = INDEX_W'($urandom_range(0, PALETTE_DEPTH - 1));
		return item;
	endfunction

	function automatic npc_req_t color_query(logic [COLOR_W-1:0] rgb, logic excl_on,
		logic [INDEX_W-1:0] excl_ix);
		npc_req_t item;
		item.kind           = KIND_QUERY;
		item.entry_index    = INDEX_W'($urandom_range(0, PALETTE_DEPTH - 1));
		{item.red, item.green, item.blue} = rgb;
		item.exclude_enable = excl_on;
		item.exclude_index  = excl_ix;
		return item;
	endfunction

	// Moves a channel by up to three steps, clamped to the channel range, so
	// that queries land close to stored entries and produce near ties.
	function automatic logic [CHAN_W-1:0] nudge(logic [CHAN_W-1:0] ch);
		int v;
		v = int'(ch) + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[CHAN_W-1:0];
	endfunction

	// Presents one request and holds it until the block takes the transfer.
	// Valid stays high from one transfer to the next unless a gap is drawn.
	task automatic send_item(input npc_req_t item);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall !== 1'b0);
		matcher.note_request(item);
	endtask

	// Stops sending and waits for every owed result. Writes give no result,
	// so a further settling time covers any write or search still under way.
	task automatic wait_idle();
		req_valid <= 1'b0;
		while (matcher.expected_matches.size() != 0)
			@(posedge clk);
		repeat (QUERY_SETTLE) @(posedge clk);
	endtask

	task automatic set_palette_size(input logic [SIZE_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		matcher.size = value;
	endtask

	// Every entry is written before the first query, so no query ever reads
	// an entry that has not been loaded.
	task automatic directed_items();
		logic [COLOR_W-1:0] twin;
		twin = COLOR_W'($urandom);
		send_item(palette_write(4'd0, 24'h000000));
		send_item(palette_write(4'd1, 24'hFF0000));
		send_item(palette_write(4'd2, 24'h00FF00));
		send_item(palette_write(4'd3, 24'h0000FF));
		// Entries 4 and 5 are equal, so a query of that colour is a tie.
		send_item(palette_write(4'd4, twin));
		send_item(palette_write(4'd5, twin));
		for (int k = 6; k < 15; k++)
			send_item(palette_write(INDEX_W'(k), COLOR_W'($urandom)));
		send_item(palette_write(4'd15, 24'hFFFFFF));

		// Exact match on black, then the same with entry zero ruled out.
		send_item(color_query(24'h000000, 1'b0, 4'd0));
		send_item(color_query(24'h000000, 1'b1, 4'd0));
		send_item(color_query(24'hFFFFFF, 1'b1, 4'd15));
		// Tie goes to the lower entry; excluding it hands the win to its twin.
		send_item(color_query(twin, 1'b0, 4'd5));
		send_item(color_query(twin, 1'b1, 4'd4));

		// With one black entry, white is the largest distance there is.
		set_palette_size(5'd1);
		send_item(color_query(24'hFFFFFF, 1'b0, 4'd0));
		// Every searched entry excluded: nothing is found.
		send_item(color_query(24'h808080, 1'b1, 4'd0));
		// An excluded index past the searched size rules nothing out.
		send_item(color_query(24'h123456, 1'b1, 4'd9));

		set_palette_size(5'd0);
		send_item(color_query(COLOR_W'($urandom), 1'b0, 4'd3));

		// Sizes above the depth search the whole palette.
		set_palette_size(5'd31);
		send_item(color_query(COLOR_W'($urandom), 1'b1, 4'd15));
	endtask

	task automatic random_items(input int unsigned count);
		npc_req_t           item;
		logic [COLOR_W-1:0] rgb;
		logic [COLOR_W-1:0] near;
		logic [INDEX_W-1:0] excl_ix;
		repeat (count) begin
			if ($urandom_range(0, 3) == 0) begin
				// About a quarter of the writes copy another entry to make ties.
				if ($urandom_range(0, 3) == 0)
					rgb = matcher.palette[$urandom_range(0, PALETTE_DEPTH - 1)];
				else
					rgb = COLOR_W'($urandom);
				item = palette_write(INDEX_W'($urandom_range(0, PALETTE_DEPTH - 1)), rgb);
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					rgb = COLOR_W'($urandom);
				end else begin
					near = matcher.palette[$urandom_range(0, PALETTE_DEPTH - 1)];
					rgb  = {nudge(near[2*CHAN_W +: CHAN_W]), nudge(near[CHAN_W +: CHAN_W]),
						nudge(near[0 +: CHAN_W])};
				end
				// Low indices are favoured so that exclusion bites at small sizes too.
				if ($urandom_range(0, 1) == 0)
					excl_ix = INDEX_W'($urandom_range(0, 3));
				else
					excl_ix = INDEX_W'($urandom_range(0, PALETTE_DEPTH - 1));
				item = color_query(rgb, 1'($urandom_range(0, 1)), excl_ix);
			end
			send_item(item);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();

		for (int p = 0; p < PHASES; p++) begin
			// One quiet phase in the middle and none at all at the end.
			idling_on <= (p != 4) && (p != PHASES - 1);
			if (p == 7)
				set_palette_size(SIZE_W'($urandom_range(1, 31)));
			else
				set_palette_size(PHASE_SIZES[p]);
			random_items(PHASE_ITEMS / 2);
			// The sender also holds back once in mid-phase until all is drained.
			if (p == 2)
				wait_idle();
			random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
		end

		wait_idle();
		if (matcher.errors == 0)
			$display("nearest_palette_color_unit_tb: done, clean");
		else
			$display("nearest_palette_color_unit_tb: done, errors");
		$finish;
	end

endmodule

[nearest_palette_color_unit.f]
+incdir+rtl
rtl/npc_pkg.sv
rtl/npc_ram.sv
rtl/nearest_palette_color_unit.sv
bench/nearest_palette_color_unit_tb.sv
